FILE: hdl/sda_pkg.sv
// Shared types, constants and helpers for the spring-damper animator.
package sda_pkg;

    localparam int FRAC_BITS_DEF = 16;

    // Configuration register map (word index) and reset values
    localparam logic [2:0] REG_STIFFNESS  = 3'd0;
    localparam logic [2:0] REG_DAMPING    = 3'd1;
    localparam logic [2:0] REG_MASS       = 3'd2;
    localparam logic [2:0] REG_REST_DELTA = 3'd3;
    localparam logic [2:0] REG_REST_SPEED = 3'd4;

    localparam logic [31:0] STIFFNESS_RST  = 32'd6553600;
    localparam logic [31:0] DAMPING_RST    = 32'd655360;
    localparam logic [31:0] MASS_RST       = 32'd65536;
    localparam logic [30:0] REST_DELTA_RST = 31'd655;
    localparam logic [30:0] REST_SPEED_RST = 31'd655;

    // Input actions
    localparam logic [1:0] ACT_TICK     = 2'd0;
    localparam logic [1:0] ACT_SET      = 2'd1;
    localparam logic [1:0] ACT_TELEPORT = 2'd2;

    // Time step
    localparam int          MS_W      = 6;
    localparam logic [15:0] DT_CAP_MS = 16'd50;
    localparam logic [31:0] MS_PER_S  = 32'd1000;

    // Serial divider for the divide by mass: dividend width and step count
    localparam int DIV_W      = 68;
    localparam int CNT_W      = 7;
    localparam int DIV_N_ACC  = 65;
    localparam int ACC_W      = 63;
    localparam logic [DIV_W-1:0] ACC_CAP = DIV_W'(1) << 62;

    // Divide by 1000 in 17-bit chunks: remainder and chunk form a 27-bit
    // partial dividend whose quotient digit comes from a reciprocal multiply
    localparam int          KD_CHUNK = 17;
    localparam int          KD_VAL_W = 27;
    localparam int          KD_SHIFT = 37;
    localparam logic [27:0] KD_RECIP = 28'd137438954;
    localparam int          KD_N_DV  = 4;
    localparam int          KD_N_DP  = 3;

    typedef struct packed {
        logic [31:0] stiffness;
        logic [31:0] damping;
        logic [31:0] mass;
        logic [30:0] rest_delta;
        logic [30:0] rest_speed;
    } t_cfg;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD,
        OP_SET_TARGET,
        OP_TELEPORT,
        OP_SNAP,
        OP_MUL_K,
        OP_MUL_C,
        OP_DIV_FORCE,
        OP_CAP_ACC,
        OP_DIV_DV,
        OP_UPD_V,
        OP_DIV_DP,
        OP_UPD_P,
        OP_PUBLISH
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
    } t_dp_cmd;

    typedef struct packed {
        logic [1:0] action;
        logic       settled;
        logic       at_rest;
        logic       div_busy;
    } t_dp_stat;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_MUL_K,
        ST_MUL_C,
        ST_FORCE,
        ST_DIV_ACC,
        ST_CAP_ACC,
        ST_SCALE_ACC,
        ST_DIV_DV,
        ST_UPD_V,
        ST_SCALE_V,
        ST_DIV_DP,
        ST_UPD_P,
        ST_PUBLISH
    } t_state;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] res;
        if (v > 64'sd2147483647) begin
            res = 32'sh7FFF_FFFF;
        end else if (v < -64'sd2147483648) begin
            res = 32'sh8000_0000;
        end else begin
            res = v[31:0];
        end
        return res;
    endfunction

    function automatic logic [31:0] mag32(input logic signed [31:0] v);
        return v[31] ? 32'(-v) : 32'(v);
    endfunction

endpackage

FILE: hdl/spring_damper_animator.sv
// Top level of the spring-damper animator.
//
// Input channel (i_in_valid/o_in_ready) takes one item per transaction:
// i_action selects tick, set target or teleport; i_value carries the
// target or teleport value (signed Q16.16); i_elapsed_ms the tick time.
// Output channel (o_out_valid/i_out_ready) gives one transaction per item:
// the current position and the done flag after that item.
// Items are processed one at a time. Set target, teleport, settled ticks,
// snapping ticks and unused actions go from decode straight to the publish
// state that loads the result register. A moving tick adds the two multiplies,
// 65 divider steps for the divide by mass and 4 and 3 chunk steps for the
// divides by 1000 that scale the velocity and position by the time step.
// The input is ready again once the result sits in the output register, so
// a new item is taken while the previous result waits; if the receiver
// stalls, the next result holds in the controller until the register frees.
// Reset (synchronous, active low) brings back register defaults, zero
// position, velocity and target, the settled flag, and an empty output.
// The APB port writes and reads k, c, m and the two rest thresholds.
module spring_damper_animator import sda_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [1:0]         i_action,
    input  logic signed [31:0] i_value,
    input  logic [15:0]        i_elapsed_ms,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [31:0] o_position,
    output logic               o_done_res,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    t_cfg     cfg;
    t_dp_cmd  cmd;
    t_dp_stat stat;

    sda_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    sda_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    sda_dp #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_cmd        (cmd),
        .i_action     (i_action),
        .i_value      (i_value),
        .i_elapsed_ms (i_elapsed_ms),
        .o_position   (o_position),
        .o_done_res   (o_done_res),
        .o_stat       (stat)
    );

endmodule

FILE: hdl/sda_regs.sv
// APB configuration registers of the spring-damper animator.
module sda_regs import sda_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output t_cfg        o_cfg
);

    t_cfg       r_cfg;
    logic       wr_en;
    logic [2:0] idx;

    assign idx    = paddr[4:2];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.stiffness  <= STIFFNESS_RST;
            r_cfg.damping    <= DAMPING_RST;
            r_cfg.mass       <= MASS_RST;
            r_cfg.rest_delta <= REST_DELTA_RST;
            r_cfg.rest_speed <= REST_SPEED_RST;
        end else if (wr_en) begin
            case (idx)
                REG_STIFFNESS:  r_cfg.stiffness  <= pwdata;
                REG_DAMPING:    r_cfg.damping    <= pwdata;
                REG_MASS:       r_cfg.mass       <= pwdata;
                REG_REST_DELTA: r_cfg.rest_delta <= pwdata[30:0];
                REG_REST_SPEED: r_cfg.rest_speed <= pwdata[30:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_STIFFNESS:  prdata = r_cfg.stiffness;
            REG_DAMPING:    prdata = r_cfg.damping;
            REG_MASS:       prdata = r_cfg.mass;
            REG_REST_DELTA: prdata = {1'b0, r_cfg.rest_delta};
            REG_REST_SPEED: prdata = {1'b0, r_cfg.rest_speed};
            default:        prdata = 32'd0;
        endcase
    end

endmodule

FILE: hdl/sda_dp.sv
// Datapath: motion state, shared multiplier, serial divider and chunked divide by 1000.
module sda_dp import sda_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cfg               i_cfg,
    input  t_dp_cmd            i_cmd,
    input  logic [1:0]         i_action,
    input  logic signed [31:0] i_value,
    input  logic [15:0]        i_elapsed_ms,
    output logic signed [31:0] o_position,
    output logic               o_done_res,
    output t_dp_stat           o_stat
);

    // motion state
    logic signed [31:0] r_pos, r_vel, r_tgt;
    logic               r_settled;
    // latched item
    logic [1:0]         r_action;
    logic signed [31:0] r_val;
    logic [MS_W-1:0]    r_ms;
    // force and acceleration
    logic [63:0]        r_prod, r_fs;
    logic               r_xneg, r_fneg;
    logic [ACC_W-1:0]   r_acc;
    // divider
    logic [DIV_W-1:0]   r_quo;
    logic [31:0]        r_rem, r_dsor;
    logic [CNT_W-1:0]   r_cnt;
    logic               r_kdiv;
    // result register
    logic signed [31:0] r_out_pos;
    logic               r_out_done;

    logic signed [32:0] x33;
    logic [32:0]        x_mag, v_mag33;
    logic signed [31:0] xc;
    logic [31:0]        mul_a, mul_b, v_mag, mass_eff;
    logic signed [65:0] fk, fc, force_s;
    logic [65:0]        n_mag;
    logic [DIV_W-1:0]   n_sh, dvd_acc, dvd_dv, dvd_dp;
    logic [32:0]        rem_sh;
    logic               q_bit;
    logic [KD_VAL_W-1:0]  kd_val, kd_r;
    logic [KD_VAL_W+27:0] kd_prod;
    logic [KD_CHUNK-1:0]  kd_q;
    logic signed [63:0] dv64, dp64, v_sum, p_sum;

    assign x33     = 33'(r_tgt) - 33'(r_pos);
    assign x_mag   = x33[32] ? 33'(-x33) : 33'(x33);
    assign v_mag33 = r_vel[31] ? 33'(-33'(r_vel)) : 33'(r_vel);
    assign xc      = sat32(64'(x33));
    assign v_mag   = mag32(r_vel);
    assign mass_eff = (i_cfg.mass == 32'd0) ? 32'd1 : i_cfg.mass;

    assign mul_a = (i_cmd.op == OP_MUL_K) ? mag32(xc) : v_mag;
    assign mul_b = (i_cmd.op == OP_MUL_K) ? i_cfg.stiffness : i_cfg.damping;

    // force = k*x - c*v, each term truncated in magnitude
    assign fk      = r_xneg ? -66'(r_fs) : 66'(r_fs);
    assign fc      = r_vel[31] ? -66'(r_prod >> FRAC_BITS) : 66'(r_prod >> FRAC_BITS);
    assign force_s = fk - fc;
    assign n_mag   = force_s[65] ? 66'(-force_s) : 66'(force_s);
    assign n_sh    = DIV_W'(n_mag) << FRAC_BITS;

    // dividends, left aligned to the step count
    assign dvd_acc = n_sh << (DIV_W - DIV_N_ACC);
    assign dvd_dv  = (DIV_W'(r_acc) * DIV_W'(r_ms)) << (DIV_W - KD_N_DV * KD_CHUNK);
    assign dvd_dp  = (DIV_W'(v_mag) * DIV_W'(r_ms)) << (DIV_W - KD_N_DP * KD_CHUNK);

    assign rem_sh = {r_rem, r_quo[DIV_W-1]};
    assign q_bit  = rem_sh >= {1'b0, r_dsor};

    // one quotient digit of the divide by 1000 per cycle
    assign kd_val  = {r_rem[KD_VAL_W-KD_CHUNK-1:0], r_quo[DIV_W-1 -: KD_CHUNK]};
    assign kd_prod = {28'd0, kd_val} * {27'd0, KD_RECIP};
    assign kd_q    = KD_CHUNK'(kd_prod >> KD_SHIFT);
    assign kd_r    = kd_val - KD_VAL_W'(kd_q) * KD_VAL_W'(MS_PER_S);

    assign dv64  = 64'({6'd0, r_quo[57:0]});
    assign dp64  = 64'({32'd0, r_quo[31:0]});
    assign v_sum = 64'(r_vel) + (r_fneg ? -dv64 : dv64);
    assign p_sum = 64'(r_pos) + (r_vel[31] ? -dp64 : dp64);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= '0;
            r_vel     <= '0;
            r_tgt     <= '0;
            r_settled <= 1'b1;
            r_cnt     <= '0;
            r_kdiv    <= 1'b0;
        end else begin
            if (r_cnt != '0) begin
                if (r_kdiv) begin
                    r_rem <= 32'(kd_r);
                    r_quo <= {r_quo[DIV_W-KD_CHUNK-1:0], kd_q};
                end else begin
                    r_rem <= q_bit ? 32'(rem_sh - {1'b0, r_dsor}) : rem_sh[31:0];
                    r_quo <= {r_quo[DIV_W-2:0], q_bit};
                end
                r_cnt <= r_cnt - CNT_W'(1);
            end
            case (i_cmd.op)
                OP_SET_TARGET: begin
                    if (r_settled) begin
                        r_vel <= '0;
                    end
                    r_tgt     <= r_val;
                    r_settled <= 1'b0;
                end
                OP_TELEPORT: begin
                    r_pos     <= r_val;
                    r_tgt     <= r_val;
                    r_vel     <= '0;
                    r_settled <= 1'b1;
                end
                OP_SNAP: begin
                    r_pos     <= r_tgt;
                    r_settled <= 1'b1;
                end
                OP_DIV_FORCE: begin
                    r_quo  <= dvd_acc;
                    r_rem  <= '0;
                    r_dsor <= mass_eff;
                    r_kdiv <= 1'b0;
                    r_cnt  <= CNT_W'(DIV_N_ACC);
                end
                OP_DIV_DV: begin
                    r_quo  <= dvd_dv;
                    r_rem  <= '0;
                    r_kdiv <= 1'b1;
                    r_cnt  <= CNT_W'(KD_N_DV);
                end
                OP_DIV_DP: begin
                    r_quo  <= dvd_dp;
                    r_rem  <= '0;
                    r_kdiv <= 1'b1;
                    r_cnt  <= CNT_W'(KD_N_DP);
                end
                OP_UPD_V: r_vel <= sat32(v_sum);
                OP_UPD_P: r_pos <= sat32(p_sum);
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LOAD: begin
                r_action <= i_action;
                r_val    <= i_value;
                r_ms     <= (i_elapsed_ms > DT_CAP_MS) ? MS_W'(DT_CAP_MS) : i_elapsed_ms[MS_W-1:0];
            end
            OP_MUL_K: begin
                r_prod <= {32'd0, mul_a} * {32'd0, mul_b};
                r_xneg <= xc[31];
            end
            OP_MUL_C: begin
                r_prod <= {32'd0, mul_a} * {32'd0, mul_b};
                r_fs   <= r_prod >> FRAC_BITS;
            end
            OP_DIV_FORCE: r_fneg <= force_s[65];
            OP_CAP_ACC:   r_acc  <= (r_quo > ACC_CAP) ? ACC_CAP[ACC_W-1:0] : r_quo[ACC_W-1:0];
            OP_PUBLISH: begin
                r_out_pos  <= r_pos;
                r_out_done <= r_settled;
            end
            default: ;
        endcase
    end

    assign o_stat.action   = r_action;
    assign o_stat.settled  = r_settled;
    assign o_stat.at_rest  = (x_mag <= 33'(i_cfg.rest_delta)) &&
                             (v_mag33 <= 33'(i_cfg.rest_speed));
    assign o_stat.div_busy = (r_cnt != '0);
    assign o_position      = r_out_pos;
    assign o_done_res      = r_out_done;

endmodule

FILE: hdl/sda_ctrl.sv
// Controller state machine sequencing one item through the datapath.
module sda_ctrl import sda_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd.op    = OP_NOP;
        o_in_ready  = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.op = OP_LOAD;
                    n_state  = ST_DECODE;
                end
            end
            ST_DECODE: begin
                n_state = ST_PUBLISH;
                case (i_stat.action)
                    ACT_TICK: begin
                        if (!i_stat.settled) begin
                            if (i_stat.at_rest) begin
                                o_cmd.op = OP_SNAP;
                            end else begin
                                n_state = ST_MUL_K;
                            end
                        end
                    end
                    ACT_SET:      o_cmd.op = OP_SET_TARGET;
                    ACT_TELEPORT: o_cmd.op = OP_TELEPORT;
                    default: ;
                endcase
            end
            ST_MUL_K: begin
                o_cmd.op = OP_MUL_K;
                n_state  = ST_MUL_C;
            end
            ST_MUL_C: begin
                o_cmd.op = OP_MUL_C;
                n_state  = ST_FORCE;
            end
            ST_FORCE: begin
                o_cmd.op = OP_DIV_FORCE;
                n_state  = ST_DIV_ACC;
            end
            ST_DIV_ACC: begin
                if (!i_stat.div_busy) begin
                    n_state = ST_CAP_ACC;
                end
            end
            ST_CAP_ACC: begin
                o_cmd.op = OP_CAP_ACC;
                n_state  = ST_SCALE_ACC;
            end
            ST_SCALE_ACC: begin
                o_cmd.op = OP_DIV_DV;
                n_state  = ST_DIV_DV;
            end
            ST_DIV_DV: begin
                if (!i_stat.div_busy) begin
                    n_state = ST_UPD_V;
                end
            end
            ST_UPD_V: begin
                o_cmd.op = OP_UPD_V;
                n_state  = ST_SCALE_V;
            end
            ST_SCALE_V: begin
                o_cmd.op = OP_DIV_DP;
                n_state  = ST_DIV_DP;
            end
            ST_DIV_DP: begin
                if (!i_stat.div_busy) begin
                    n_state = ST_UPD_P;
                end
            end
            ST_UPD_P: begin
                o_cmd.op = OP_UPD_P;
                n_state  = ST_PUBLISH;
            end
            ST_PUBLISH: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.op    = OP_PUBLISH;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_out_valid = r_out_valid;

endmodule

FILE: hdl/sda_chk.sv
// Port-level checker for the spring-damper animator, bound to the top level.
module sda_chk import sda_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [31:0] o_position,
    input logic        o_done_res,
    input logic        psel,
    input logic        penable,
    input logic        pwrite,
    input logic [4:0]  paddr,
    input logic [31:0] pwdata,
    input logic [31:0] prdata,
    input logic        pready
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result transaction dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_position) && $stable(o_done_res))
        else $error("stalled result changed");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("second item taken while one is in flight");

    a_reg_readback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        psel && penable && pwrite && pready &&
        (paddr[4:2] == REG_STIFFNESS || paddr[4:2] == REG_DAMPING ||
         paddr[4:2] == REG_MASS)
        |=> (paddr != $past(paddr)) || (prdata == $past(pwdata)))
        else $error("register readback differs from written value");

    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && o_in_ready)
        else $error("block not idle after reset");

endmodule

bind spring_damper_animator sda_chk u_sda_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_position  (o_position),
    .o_done_res  (o_done_res),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
);

FILE: verif/sda_checker.sv
// Scoreboard for the spring-damper animator: tracks the motion state and checks every result.
module sda_checker import sda_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  logic [1:0]         i_action,
    input  logic signed [31:0] i_value,
    input  logic [15:0]        i_elapsed_ms,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  logic signed [31:0] i_position,
    input  logic               i_done_res,
    input  logic               i_psel,
    input  logic               i_penable,
    input  logic               i_pwrite,
    input  logic               i_pready,
    input  logic [4:0]         i_paddr,
    input  logic [31:0]        i_pwdata,
    output int                 o_fail_count,
    output int                 o_pending,
    output int                 o_checked,
    output int                 o_settled_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic signed [31:0] position;
        logic               done;
    } t_frame;

    t_frame frames_due[$];
    t_frame due;
    t_cfg   cfg;
    longint pos_q;
    longint vel_q;
    longint tgt_q;
    bit     at_rest;
    int     mismatches;
    int     compared;
    int     settled_seen;

    function automatic logic [63:0] abs64(input longint v);
        return (v < 0) ? 64'(-v) : 64'(v);
    endfunction

    function automatic longint clip32(input longint v);
        if (v > 64'sd2147483647) begin
            return 64'sd2147483647;
        end else if (v < -64'sd2147483648) begin
            return -64'sd2147483648;
        end
        return v;
    endfunction

    function automatic longint signed_mag(input bit neg, input logic [63:0] m);
        return neg ? -longint'(m) : longint'(m);
    endfunction

    function automatic logic [63:0] times_dt(input logic [63:0] m, input logic [63:0] ms);
        logic [63:0] per_s;
        per_s = 64'(MS_PER_S);
        return (m / per_s) * ms + ((m % per_s) * ms) / per_s;
    endfunction

    // one semi-implicit Euler step, or a snap onto the target when at rest
    function automatic void spring_advance(input logic [15:0] elapsed);
        logic [63:0] ms;
        logic [63:0] fs;
        logic [63:0] fd;
        logic [63:0] m;
        logic [63:0] n;
        logic [63:0] q;
        logic [63:0] r;
        logic [63:0] acc;
        logic [63:0] acc_cap;
        longint      x;
        longint      xc;
        longint      force_v;
        longint      dv;
        longint      dp;
        x       = tgt_q - pos_q;
        ms      = (elapsed > DT_CAP_MS) ? 64'(DT_CAP_MS) : 64'(elapsed);
        acc_cap = 64'd1 << 62;
        if (abs64(x) <= 64'(cfg.rest_delta) && abs64(vel_q) <= 64'(cfg.rest_speed)) begin
            pos_q   = tgt_q;
            at_rest = 1'b1;
        end else begin
            xc      = clip32(x);
            fs      = (abs64(xc) * 64'(cfg.stiffness)) >> FRAC_BITS_DEF;
            fd      = (abs64(vel_q) * 64'(cfg.damping)) >> FRAC_BITS_DEF;
            force_v = signed_mag(xc < 0, fs) - signed_mag(vel_q < 0, fd);
            m       = (cfg.mass == 32'd0) ? 64'd1 : 64'(cfg.mass);
            n       = abs64(force_v);
            q       = n / m;
            r       = n % m;
            if (q >= (acc_cap >> FRAC_BITS_DEF)) begin
                acc = acc_cap;
            end else begin
                acc = (q << FRAC_BITS_DEF) + (r << FRAC_BITS_DEF) / m;
                if (acc > acc_cap) begin
                    acc = acc_cap;
                end
            end
            dv    = signed_mag(force_v < 0, times_dt(acc, ms));
            vel_q = clip32(vel_q + dv);
            dp    = signed_mag(vel_q < 0, times_dt(abs64(vel_q), ms));
            pos_q = clip32(pos_q + dp);
        end
    endfunction

    function automatic t_frame animate_step(input logic [1:0] act,
                                            input logic signed [31:0] val,
                                            input logic [15:0] elapsed);
        t_frame f;
        case (act)
            ACT_TICK: begin
                if (!at_rest) begin
                    spring_advance(elapsed);
                end
            end
            ACT_SET: begin
                if (at_rest) begin
                    vel_q = 0;
                end
                tgt_q   = val;
                at_rest = 1'b0;
            end
            ACT_TELEPORT: begin
                pos_q   = val;
                tgt_q   = val;
                vel_q   = 0;
                at_rest = 1'b1;
            end
            default: ;
        endcase
        f.position = pos_q[31:0];
        f.done     = at_rest;
        return f;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg.stiffness  = STIFFNESS_RST;
            cfg.damping    = DAMPING_RST;
            cfg.mass       = MASS_RST;
            cfg.rest_delta = REST_DELTA_RST;
            cfg.rest_speed = REST_SPEED_RST;
            pos_q          = 0;
            vel_q          = 0;
            tgt_q          = 0;
            at_rest        = 1'b1;
            frames_due.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[4:2])
                    REG_STIFFNESS:  cfg.stiffness  = i_pwdata;
                    REG_DAMPING:    cfg.damping    = i_pwdata;
                    REG_MASS:       cfg.mass       = i_pwdata;
                    REG_REST_DELTA: cfg.rest_delta = i_pwdata[30:0];
                    REG_REST_SPEED: cfg.rest_speed = i_pwdata[30:0];
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                if (frames_due.size() == 0) begin
                    if (mismatches < 10) begin
                        $display("unexpected result: position %h done %0d",
                                 i_position, i_done_res);
                    end
                    mismatches++;
                end else begin
                    due = frames_due.pop_front();
                    if (i_position !== due.position || i_done_res !== due.done) begin
                        if (mismatches < 10) begin
                            $display("result %0d: position exp %h got %h, done exp %0d got %0d",
                                     compared, due.position, i_position, due.done,
                                     i_done_res);
                        end
                        mismatches++;
                    end
                    if (due.done) begin
                        settled_seen++;
                    end
                    compared++;
                end
            end
            if (i_in_valid && i_in_ready) begin
                frames_due.push_back(animate_step(i_action, i_value, i_elapsed_ms));
            end
        end
        o_pending      <= frames_due.size();
        o_fail_count   <= mismatches;
        o_checked      <= compared;
        o_settled_seen <= settled_seen;
    end

endmodule

FILE: verif/tb_spring_damper_animator.sv
// Testbench top for the spring-damper animator: stimulus, register settings and verdict.
module tb_spring_damper_animator;
    timeunit 1ns;
    timeprecision 1ps;
    import sda_pkg::*;

    localparam logic [1:0] ACT_UNUSED = 2'd3;

    logic               i_clk        = 1'b0;
    logic               i_rst_n      = 1'b0;
    logic               i_in_valid   = 1'b0;
    logic [1:0]         i_action     = ACT_TICK;
    logic signed [31:0] i_value      = '0;
    logic [15:0]        i_elapsed_ms = '0;
    logic               i_out_ready  = 1'b1;
    logic               psel         = 1'b0;
    logic               penable      = 1'b0;
    logic               pwrite       = 1'b0;
    logic [4:0]         paddr        = '0;
    logic [31:0]        pwdata       = '0;
    logic               o_in_ready;
    logic               o_out_valid;
    logic signed [31:0] o_position;
    logic               o_done_res;
    logic [31:0]        prdata;
    logic               pready;

    int fail_count;
    int pending;
    int checked;
    int settled_seen;

    bit idle_on = 1'b1;
    int hold_len;
    int n_items;
    int n_ticks;
    int n_sets;
    int n_teleports;
    int n_unused;
    int n_settings;
    int items_goal;

    spring_damper_animator u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_action     (i_action),
        .i_value      (i_value),
        .i_elapsed_ms (i_elapsed_ms),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_position   (o_position),
        .o_done_res   (o_done_res),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    sda_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_in_ready     (o_in_ready),
        .i_action       (i_action),
        .i_value        (i_value),
        .i_elapsed_ms   (i_elapsed_ms),
        .i_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .i_position     (o_position),
        .i_done_res     (o_done_res),
        .i_psel         (psel),
        .i_penable      (penable),
        .i_pwrite       (pwrite),
        .i_pready       (pready),
        .i_paddr        (paddr),
        .i_pwdata       (pwdata),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_checked      (checked),
        .o_settled_seen (settled_seen)
    );

    always #4 i_clk = ~i_clk;

    // receiver: short random stalls while idle_on is set, or a long hold-off on request
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_len > 0) begin
                i_out_ready <= 1'b0;
                repeat (hold_len) @(posedge i_clk);
                hold_len = 0;
                i_out_ready <= 1'b1;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge i_clk);
                i_out_ready <= 1'b1;
            end
        end
    end

    task automatic offer(input logic [1:0] act, input logic [31:0] val,
                         input logic [15:0] ms);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_action     <= act;
        i_value      <= val;
        i_elapsed_ms <= ms;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        n_items++;
        case (act)
            ACT_TICK:     n_ticks++;
            ACT_SET:      n_sets++;
            ACT_TELEPORT: n_teleports++;
            default:      n_unused++;
        endcase
    endtask

    task automatic quiesce();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic apply_setting(input logic [31:0] k, input logic [31:0] c,
                                 input logic [31:0] m, input logic [31:0] rd,
                                 input logic [31:0] rs);
        logic [2:0]  idx  [5];
        logic [31:0] word [5];
        idx  = '{REG_STIFFNESS, REG_DAMPING, REG_MASS, REG_REST_DELTA, REG_REST_SPEED};
        word = '{k, c, m, rd, rs};
        for (int i = 0; i < 5; i++) begin
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b1;
            paddr   <= {idx[i], 2'b00};
            pwdata  <= word[i];
            @(posedge i_clk);
            penable <= 1'b1;
            @(posedge i_clk);
            while (!pready) @(posedge i_clk);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        n_settings++;
    endtask

    function automatic logic [31:0] pick_value();
        int v;
        case ($urandom_range(0, 9))
            0: return $urandom();
            1: begin
                case ($urandom_range(0, 3))
                    0: return 32'h7FFF_FFFF;
                    1: return 32'h8000_0000;
                    2: return 32'h0000_0000;
                    default: return 32'hFFFF_FFFF;
                endcase
            end
            default: begin
                v = int'($urandom_range(0, 131072000)) - 65536000;
                return 32'(v);
            end
        endcase
    endfunction

    function automatic logic [15:0] pick_ms();
        case ($urandom_range(0, 9))
            0:       return 16'd0;
            1:       return 16'($urandom());
            2, 3:    return 16'($urandom_range(1, 50));
            default: return 16'd16;
        endcase
    endfunction

    // a target change, jump or unused action followed by a run of frames, mixed with a few more of those
    task automatic run_gesture();
        int ticks;
        int pick;
        ticks = $urandom_range(4, 30);
        case ($urandom_range(0, 9))
            0:       offer(ACT_TELEPORT, pick_value(), 16'($urandom()));
            1:       offer(ACT_UNUSED, $urandom(), 16'($urandom()));
            default: offer(ACT_SET, pick_value(), 16'($urandom()));
        endcase
        repeat (ticks) begin
            pick = $urandom_range(0, 29);
            if (pick == 0) begin
                offer(ACT_SET, pick_value(), 16'($urandom()));
            end else if (pick == 1) begin
                offer(ACT_UNUSED, $urandom(), 16'($urandom()));
            end else if (pick == 2) begin
                offer(ACT_TELEPORT, pick_value(), 16'($urandom()));
            end else begin
                offer(ACT_TICK, $urandom(), pick_ms());
            end
        end
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        offer(ACT_TICK, 32'h0000_0000, 16'd16);
        offer(ACT_UNUSED, 32'h7FFF_FFFF, 16'hFFFF);
        offer(ACT_SET, 32'h000A_0000, 16'd0);
        offer(ACT_TICK, 32'hFFFF_FFFF, 16'd0);
        offer(ACT_TICK, 32'h0000_0000, 16'hFFFF);
        offer(ACT_TICK, 32'h5555_5555, 16'h5555);
        offer(ACT_TICK, 32'hAAAA_AAAA, 16'hAAAA);
        offer(ACT_TICK, 32'h0000_0000, 16'd50);
        offer(ACT_TICK, 32'h0000_0000, 16'd1);
        offer(ACT_SET, 32'hFFFF_FFFF, 16'd0);
        offer(ACT_TICK, 32'h0000_0000, 16'd16);
        offer(ACT_TELEPORT, 32'h0005_0000, 16'd0);
        offer(ACT_SET, 32'h0005_0000, 16'd0);
        offer(ACT_TICK, 32'h0000_0000, 16'd16);
        offer(ACT_TELEPORT, 32'h7FFF_FFFF, 16'd0);
        offer(ACT_SET, 32'h8000_0000, 16'd0);
        repeat (3) offer(ACT_TICK, 32'h0000_0000, 16'd50);
        offer(ACT_TELEPORT, 32'h8000_0000, 16'd0);
        offer(ACT_SET, 32'h7FFF_FFFF, 16'd0);
        repeat (2) offer(ACT_TICK, 32'h0000_0000, 16'd50);
        offer(ACT_TELEPORT, 32'h0000_0000, 16'd0);

        for (int p = 0; p < 10; p++) begin
            quiesce();
            case (p)
                0: apply_setting(STIFFNESS_RST, DAMPING_RST, MASS_RST,
                                 32'(REST_DELTA_RST), 32'(REST_SPEED_RST));
                1: apply_setting('1, '1, 32'd0, 32'h8000_0000, 32'd0);
                2: apply_setting(32'd0, 32'd0, '1, '1, 32'h7FFF_FFFF);
                3: apply_setting('1, 32'd0, 32'd1, 32'd0, 32'd0);
                4: apply_setting($urandom(), $urandom(), $urandom(), $urandom(), $urandom());
                9: begin
                    idle_on = 1'b0;
                    apply_setting(STIFFNESS_RST, DAMPING_RST, MASS_RST,
                                  32'(REST_DELTA_RST), 32'(REST_SPEED_RST));
                end
                default: apply_setting($urandom_range(1 << 16, 400 << 16),
                                       $urandom_range(0, 40 << 16),
                                       $urandom_range(1 << 12, 8 << 16),
                                       $urandom_range(0, 1 << 16),
                                       $urandom_range(0, 1 << 16));
            endcase
            if (p == 5) begin
                // long receiver hold-off while frames keep coming
                hold_len = 400;
                run_gesture();
            end
            items_goal = n_items + 200;
            while (n_items < items_goal) run_gesture();
        end

        quiesce();
        repeat (200) @(posedge i_clk);
        $display("covered %0d ticks, %0d target changes, %0d teleports, %0d unused actions",
                 n_ticks, n_sets, n_teleports, n_unused);
        $display("over %0d register settings; %0d results compared, %0d reporting settled",
                 n_settings, checked, settled_seen);
        if (fail_count == 0) begin
            $display("spring_damper_animator test passed");
        end else begin
            $display("spring_damper_animator test failed");
        end
        $finish;
    end

    initial begin
        #40ms;
        $display("spring_damper_animator test failed");
        $finish;
    end

endmodule
